// ===== src/ssp_pkg.sv =====
package ssp_pkg;

  // Field widths of the stream items and the configuration port.
  localparam int POS_W       = 11;
  localparam int REQ_W       = 12;
  localparam int SPEED_IN_W  = 8;
  localparam int SPEED_W     = 7;
  localparam int MASK_W      = 64;
  localparam int PULSE_W     = 16;
  localparam int NUM_W       = POS_W + PULSE_W;
  localparam int IN_TDATA_W  = 88;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 24;
  localparam int APB_ADDR_W  = 4;
  localparam int APB_DATA_W  = 32;

  // Fastest move: one step in every slot of the tick window.
  localparam int SPEED_MAX = 64;

  // Parameter defaults.
  localparam int RANGE_TICKS_DEF      = 1440;
  localparam int STEP_PER_TICK_DEF    = 1;
  localparam int DEFAULT_PULSE_US_DEF = 1500;
  localparam int DEFAULT_POSITION_DEF = 720;

  // Register reset values.
  localparam logic [PULSE_W-1:0] MIN_PULSE_RST = 16'd1000;
  localparam logic [PULSE_W-1:0] MAX_PULSE_RST = 16'd2000;

  // Register indexes, taken from the word address.
  localparam logic [1:0] REG_MIN_PULSE = 2'd0;
  localparam logic [1:0] REG_MAX_PULSE = 2'd1;
  localparam logic [1:0] REG_ATTACHED  = 2'd2;

  typedef enum logic [1:0] {
    CMD_TICK = 2'd0,
    CMD_JUMP = 2'd1,
    CMD_MOVE = 2'd2
  } ssp_cmd_e;

  typedef struct packed {
    ssp_cmd_e                cmd;
    logic [REQ_W-1:0]        position;
    logic [SPEED_IN_W-1:0]   speed;
    logic [MASK_W-1:0]       tick_mask;
  } ssp_in_t;

  typedef struct packed {
    logic [PULSE_W-1:0] min_pulse;
    logic [PULSE_W-1:0] max_pulse;
    logic               attached;
  } ssp_cfg_t;

  // What the position stage hands to the pulse mapping.
  typedef struct packed {
    logic             accepted;
    logic             done;
    logic             is_tick;
    logic [POS_W-1:0] pos;
  } ssp_item_t;

  typedef struct packed {
    logic accepted;
    logic done;
    logic is_tick;
  } ssp_meta_t;

  typedef struct packed {
    logic               accepted;
    logic [PULSE_W-1:0] pulse_us;
    logic               pulse_changed;
    logic               at_target;
  } ssp_result_t;

  typedef struct packed {
    logic             done;
    logic [POS_W-1:0] cur_pos;
    logic [POS_W-1:0] tgt_pos;
  } ssp_status_t;

endpackage

// ===== src/ssp_cfg.sv =====
module ssp_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ssp_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [ssp_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [ssp_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready,
  output ssp_pkg::ssp_cfg_t                 cfg
);
  import ssp_pkg::*;

  logic [PULSE_W-1:0] min_r;
  logic [PULSE_W-1:0] max_r;
  logic               att_r;
  logic               wr_en;
  logic [1:0]         idx;

  assign pready = 1'b1;
  assign idx    = paddr[APB_ADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r <= MIN_PULSE_RST;
      max_r <= MAX_PULSE_RST;
      att_r <= 1'b1;
    end else if (wr_en) begin
      unique case (idx)
        REG_MIN_PULSE: min_r <= pwdata[PULSE_W-1:0];
        REG_MAX_PULSE: max_r <= pwdata[PULSE_W-1:0];
        REG_ATTACHED:  att_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_MIN_PULSE: prdata = {{(APB_DATA_W-PULSE_W){1'b0}}, min_r};
      REG_MAX_PULSE: prdata = {{(APB_DATA_W-PULSE_W){1'b0}}, max_r};
      REG_ATTACHED:  prdata = {{(APB_DATA_W-1){1'b0}}, att_r};
      default:       prdata = '0;
    endcase
  end

  assign cfg.min_pulse = min_r;
  assign cfg.max_pulse = max_r;
  assign cfg.attached  = att_r;

endmodule

// ===== src/ssp_state.sv =====
module ssp_state #(
  parameter int RANGE_TICKS      = ssp_pkg::RANGE_TICKS_DEF,
  parameter int STEP_PER_TICK    = ssp_pkg::STEP_PER_TICK_DEF,
  parameter int DEFAULT_POSITION = ssp_pkg::DEFAULT_POSITION_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  ssp_pkg::ssp_in_t     in_item,
  input  ssp_pkg::ssp_cfg_t    cfg,
  output logic                 item_valid,
  input  logic                 item_ready,
  output ssp_pkg::ssp_item_t   item,
  output ssp_pkg::ssp_status_t status
);
  import ssp_pkg::*;

  localparam logic [POS_W-1:0] RANGE_POS = POS_W'(RANGE_TICKS);
  localparam logic [POS_W-1:0] STEP_POS  = POS_W'(STEP_PER_TICK);
  localparam logic [POS_W-1:0] INIT_POS  = POS_W'(DEFAULT_POSITION);
  localparam logic [SPEED_W-1:0] SPD_MAX = SPEED_W'(SPEED_MAX);

  // Bit i is set where slot floor(i*spd/64) begins, i.e. where the low six
  // bits of i*spd fall below spd.
  function automatic logic [MASK_W-1:0] spread_mask(input logic [SPEED_W-1:0] spd);
    logic [MASK_W-1:0] m;
    logic [12:0]       prod;
    m = '0;
    for (int i = 0; i < MASK_W; i++) begin
      prod = 13'(i) * {6'd0, spd};
      m[i] = ({1'b0, prod[5:0]} < spd);
    end
    return m;
  endfunction

  logic                 s1_valid_r;
  ssp_in_t              s1_r;
  logic [POS_W-1:0]     cur_r, cur_nxt;
  logic [POS_W-1:0]     tgt_r, tgt_nxt;
  logic [SPEED_W-1:0]   speed_r, speed_nxt;
  logic [MASK_W-1:0]    mask_r, mask_nxt;
  logic                 done_r, done_nxt;
  logic                 accepted;
  logic                 fire;
  logic [POS_W-1:0]     req_pos;
  logic [SPEED_W-1:0]   spd_sat;
  logic [POS_W-1:0]     diff_up, diff_dn, step_up, step_dn;

  assign in_ready   = !s1_valid_r || item_ready;
  assign fire       = s1_valid_r && item_ready;
  assign item_valid = s1_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_r <= in_item;
    end
  end

  assign req_pos = (s1_r.position > {1'b0, RANGE_POS}) ? RANGE_POS : s1_r.position[POS_W-1:0];
  assign spd_sat = (s1_r.speed > {1'b0, SPD_MAX}) ? SPD_MAX : s1_r.speed[SPEED_W-1:0];
  assign diff_up = tgt_r - cur_r;
  assign diff_dn = cur_r - tgt_r;
  assign step_up = (diff_up < STEP_POS) ? diff_up : STEP_POS;
  assign step_dn = (diff_dn < STEP_POS) ? diff_dn : STEP_POS;

  always_comb begin
    cur_nxt   = cur_r;
    tgt_nxt   = tgt_r;
    speed_nxt = speed_r;
    mask_nxt  = mask_r;
    done_nxt  = done_r;
    accepted  = 1'b0;
    unique case (s1_r.cmd)
      CMD_TICK: begin
        accepted = 1'b1;
        if ((cur_r != tgt_r) && ((mask_r & s1_r.tick_mask) != '0)) begin
          cur_nxt = (cur_r > tgt_r) ? cur_r - step_dn : cur_r + step_up;
        end
        done_nxt = (cur_nxt == tgt_r);
      end
      CMD_JUMP: begin
        if (cfg.attached) begin
          accepted  = 1'b1;
          cur_nxt   = req_pos;
          tgt_nxt   = req_pos;
          speed_nxt = '0;
          mask_nxt  = '0;
          done_nxt  = 1'b1;
        end
      end
      CMD_MOVE: begin
        if (cfg.attached && (s1_r.speed != '0)) begin
          accepted = 1'b1;
          tgt_nxt  = req_pos;
          done_nxt = (cur_r == req_pos);
          if (speed_r != spd_sat) begin
            speed_nxt = spd_sat;
            mask_nxt  = spread_mask(spd_sat);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r   <= INIT_POS;
      tgt_r   <= INIT_POS;
      speed_r <= '0;
      mask_r  <= '0;
      done_r  <= 1'b1;
    end else if (fire) begin
      cur_r   <= cur_nxt;
      tgt_r   <= tgt_nxt;
      speed_r <= speed_nxt;
      mask_r  <= mask_nxt;
      done_r  <= done_nxt;
    end
  end

  assign item.accepted = accepted;
  assign item.done     = done_nxt;
  assign item.is_tick  = (s1_r.cmd == CMD_TICK);
  assign item.pos      = cur_nxt;

  assign status.done    = done_r;
  assign status.cur_pos = cur_r;
  assign status.tgt_pos = tgt_r;

endmodule

// ===== src/ssp_pulse.sv =====
module ssp_pulse #(
  parameter int RANGE_TICKS      = ssp_pkg::RANGE_TICKS_DEF,
  parameter int DEFAULT_PULSE_US = ssp_pkg::DEFAULT_PULSE_US_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  ssp_pkg::ssp_item_t   item,
  input  ssp_pkg::ssp_cfg_t    cfg,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ssp_pkg::ssp_result_t result
);
  import ssp_pkg::*;

  // Exact floor(n / RANGE_TICKS) for n below 2**NUM_W, as (n * MUL) >> SH.
  localparam int          L_BITS   = $clog2(RANGE_TICKS);
  localparam int          SH       = NUM_W + L_BITS;
  localparam int          PROD_W   = SH + NUM_W;
  localparam logic [63:0] MUL_FULL = ((64'd1 << SH) + 64'(RANGE_TICKS) - 64'd1)
                                     / 64'(RANGE_TICKS);
  localparam logic [NUM_W:0] MUL   = MUL_FULL[NUM_W:0];
  localparam int          V_W      = NUM_W + 2;
  localparam logic [PULSE_W-1:0] PULSE_RST = PULSE_W'(DEFAULT_PULSE_US);

  logic                 d_neg;
  logic [PULSE_W-1:0]   d_mag;
  logic [NUM_W-1:0]     n_comb;
  logic [PROD_W-1:0]    prod;

  logic                 p1_valid_r, p2_valid_r, out_valid_r;
  logic [NUM_W-1:0]     p1_n_r;
  logic [NUM_W-1:0]     p2_q_r;
  ssp_meta_t            p1_meta_r, p2_meta_r;
  ssp_result_t          res_r;
  logic [PULSE_W-1:0]   pulse_width_r, pulse_width_nxt;

  logic                 out_adv, p2_ready, p1_ready;

  logic signed [V_W-1:0] lo_s, hi_s, q_s, v;
  logic [PULSE_W-1:0]    np;

  assign out_adv    = !out_valid_r || out_ready;
  assign p2_ready   = !p2_valid_r || out_adv;
  assign p1_ready   = !p1_valid_r || p2_ready;
  assign item_ready = p1_ready;

  // Span between the limits; its sign is applied after the division so the
  // quotient truncates toward zero.
  assign d_neg  = (cfg.max_pulse < cfg.min_pulse);
  assign d_mag  = d_neg ? cfg.min_pulse - cfg.max_pulse : cfg.max_pulse - cfg.min_pulse;
  assign n_comb = {{(NUM_W-POS_W){1'b0}}, item.pos} * {{(NUM_W-PULSE_W){1'b0}}, d_mag};
  assign prod   = {{(PROD_W-NUM_W){1'b0}}, p1_n_r} * {{(PROD_W-NUM_W-1){1'b0}}, MUL};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r  <= 1'b0;
      p2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (p1_ready)  p1_valid_r  <= item_valid;
      if (p2_ready)  p2_valid_r  <= p1_valid_r;
      if (out_adv)   out_valid_r <= p2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (p1_ready && item_valid) begin
      p1_n_r    <= n_comb;
      p1_meta_r <= '{accepted: item.accepted, done: item.done, is_tick: item.is_tick};
    end
    if (p2_ready && p1_valid_r) begin
      p2_q_r    <= prod[PROD_W-1:SH];
      p2_meta_r <= p1_meta_r;
    end
  end

  // Offset, then clamp: the minimum is tested first, then the maximum.
  assign lo_s = $signed({{(V_W-PULSE_W){1'b0}}, cfg.min_pulse});
  assign hi_s = $signed({{(V_W-PULSE_W){1'b0}}, cfg.max_pulse});
  assign q_s  = $signed({2'b00, p2_q_r});
  assign v    = d_neg ? lo_s - q_s : lo_s + q_s;

  always_comb begin
    priority if (v < lo_s) begin
      np = cfg.min_pulse;
    end else if (v > hi_s) begin
      np = cfg.max_pulse;
    end else begin
      np = v[PULSE_W-1:0];
    end
  end

  // Only a tick updates the pulse width; other commands report it as is.
  assign pulse_width_nxt = p2_meta_r.is_tick ? np : pulse_width_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pulse_width_r <= PULSE_RST;
    end else if (out_adv && p2_valid_r) begin
      pulse_width_r <= pulse_width_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && p2_valid_r) begin
      res_r.accepted      <= p2_meta_r.accepted;
      res_r.pulse_us      <= pulse_width_nxt;
      res_r.pulse_changed <= p2_meta_r.is_tick && (np != pulse_width_r);
      res_r.at_target     <= p2_meta_r.done;
    end
  end

  assign out_valid = out_valid_r;
  assign result    = res_r;

endmodule

// ===== src/servo_slew_position_controller_top.sv =====
// Servo slew position controller.
//
// Each request on the input stream is a command: tick (steps the position one
// increment toward the target when the move mask shares a bit with the
// request's tick mask, then remaps the position to a pulse width), jump (sets
// position and target at once) or move (sets the target and a speed of 1 to
// 64 steps per 64-tick window). Every request yields exactly one result
// request carrying the accepted flag, the current pulse width, a pulse-changed
// flag and the at-target flag.
//
// Throughput is one request per cycle while the receiver takes results. From
// input acceptance to out_tvalid, a request passes the input register, then the
// position update together with the span product, the reciprocal multiply that
// divides by the range, and the offset and clamp, each followed by a register.
// When the receiver stalls, results wait in the output register and the
// internal stages fill; in_tready drops only once all four stages hold data.
// Reset (synchronous, active low) empties the pipeline, restores the default
// position and pulse width, clears the move speed and mask, and reloads the
// configuration registers. The APB port always has pready high; write it only
// while no request is in flight.
module servo_slew_position_controller_top #(
  parameter int RANGE_TICKS      = ssp_pkg::RANGE_TICKS_DEF,
  parameter int STEP_PER_TICK    = ssp_pkg::STEP_PER_TICK_DEF,
  parameter int DEFAULT_PULSE_US = ssp_pkg::DEFAULT_PULSE_US_DEF,
  parameter int DEFAULT_POSITION = ssp_pkg::DEFAULT_POSITION_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // position [11:0], speed [19:12], tick_mask [83:20], zero pad [87:84]
  input  logic [ssp_pkg::IN_TDATA_W-1:0]      in_tdata,
  // cmd [1:0]
  input  logic [ssp_pkg::IN_TUSER_W-1:0]      in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // accepted [0], pulse_us [16:1], pulse_changed [17], at_target [18], pad [23:19]
  output logic [ssp_pkg::OUT_TDATA_W-1:0]     out_tdata,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [ssp_pkg::APB_ADDR_W-1:0]      cfg_paddr,
  input  logic [ssp_pkg::APB_DATA_W-1:0]      cfg_pwdata,
  output logic [ssp_pkg::APB_DATA_W-1:0]      cfg_prdata,
  output logic                                cfg_pready
);
  import ssp_pkg::*;

  ssp_cfg_t    cfg;
  ssp_in_t     in_item;
  ssp_item_t   item;
  ssp_status_t status;
  ssp_result_t res;
  logic        item_valid;
  logic        item_ready;

  assign in_item.cmd       = ssp_cmd_e'(in_tuser);
  assign in_item.position  = in_tdata[REQ_W-1:0];
  assign in_item.speed     = in_tdata[REQ_W+SPEED_IN_W-1:REQ_W];
  assign in_item.tick_mask = in_tdata[REQ_W+SPEED_IN_W+MASK_W-1:REQ_W+SPEED_IN_W];

  ssp_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // Position, target and move mask live here; they update as each request
  // leaves the input register, so later requests see the result in order.
  ssp_state #(
    .RANGE_TICKS      (RANGE_TICKS),
    .STEP_PER_TICK    (STEP_PER_TICK),
    .DEFAULT_POSITION (DEFAULT_POSITION)
  ) u_state (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_item    (in_item),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .status     (status)
  );

  // The pulse width is owned by the last stage, so non-tick requests report
  // the value left by the tick just ahead of them.
  ssp_pulse #(
    .RANGE_TICKS      (RANGE_TICKS),
    .DEFAULT_PULSE_US (DEFAULT_PULSE_US)
  ) u_pulse (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .cfg        (cfg),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .result     (res)
  );

  assign out_tdata = {{(OUT_TDATA_W-PULSE_W-3){1'b0}},
                      res.at_target, res.pulse_changed, res.pulse_us, res.accepted};

  // A reset cycle always leaves the output empty.
  a_reset_empties: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // With the receiver taking results, every stage advances and input flows.
  a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("input stalled while output is ready");

  // The stored done flag always tracks position equal to target.
  a_done_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    status.done == (status.cur_pos == status.tgt_pos))
    else $error("done flag disagrees with position and target");

  // Only ticks change the pulse, and ticks are always accepted.
  a_change_accepted: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && res.pulse_changed |-> res.accepted)
    else $error("pulse changed on a rejected request");

endmodule
